// ----- sv/sse_pkg.sv -----
// ----------------------------------------------------------------------------
// Servo slew engine package
// Shared widths, reset values, register indexes, the configuration
// structure and the angle-to-duty lookup table.
// ----------------------------------------------------------------------------
package sse_pkg;

   // Lanes that have a target and a duty port of their own.
   localparam int LANES               = 4;
   localparam int SERVO_COUNT_DEFAULT = 4;

   localparam int ANGLE_W     = 8;
   localparam int TARGET_W    = 10;
   localparam int DUTY_W      = 14;
   localparam int CFG_W       = 8;
   localparam int CSR_INDEX_W = 8;
   localparam int MASK_W      = 4;

   localparam logic [ANGLE_W-1:0] ANGLE_MAX   = 8'd180;
   localparam logic [ANGLE_W-1:0] ANGLE_RESET = 8'd90;

   // Request type codes.
   localparam logic REQ_TICK = 1'b0;
   localparam logic REQ_LOAD = 1'b1;

   // Easing mode codes.
   localparam logic MODE_CONSTANT = 1'b0;
   localparam logic MODE_EASING   = 1'b1;

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CONSTANT_STEP = 8'd0,
      CSR_EASE_RATIO    = 8'd1,
      CSR_EASE_MIN      = 8'd2,
      CSR_EASE_MAX      = 8'd3
   } csr_index_type;

   // Register reset values.
   localparam logic [CFG_W-1:0] CONSTANT_STEP_RESET = 8'd5;
   localparam logic [CFG_W-1:0] EASE_RATIO_RESET    = 8'd26;
   localparam logic [CFG_W-1:0] EASE_MIN_RESET      = 8'd1;
   localparam logic [CFG_W-1:0] EASE_MAX_RESET      = 8'd10;

   // Configuration as seen by every lane.
   typedef struct packed {
      logic [CFG_W-1:0] constant_step;
      logic [CFG_W-1:0] ease_ratio_q8;
      logic [CFG_W-1:0] ease_min_step;
      logic [CFG_W-1:0] ease_max_step;
   } cfg_type;

   // Duty = floor((4500 + 100 * angle) * 16383 / 180000).
   localparam int DutyBase  = 4500;
   localparam int DutyScale = 100;
   localparam int DutyGain  = 16383;
   localparam int DutyDen   = 180000;
   localparam int TableSize = 2 ** ANGLE_W;

   typedef logic [TableSize-1:0][DUTY_W-1:0] duty_table_type;

   // Built once at elaboration; entries above 180 degrees are never used.
   function automatic duty_table_type build_duty_table();
      duty_table_type tbl;
      for (int i = 0; i < TableSize; i++) begin
         tbl[i] = DUTY_W'(((DutyBase + DutyScale * i) * DutyGain) / DutyDen);
      end
      return tbl;
   endfunction

   localparam duty_table_type DUTY_TABLE = build_duty_table();

endpackage

// ----- sv/sse_lane.sv -----
// ----------------------------------------------------------------------------
// Servo slew lane
// Holds one servo's angle, goal and mode, takes new goals on a load and
// moves one step toward the goal on a tick, never past it.
// ----------------------------------------------------------------------------
module sse_lane
   import sse_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       load_en,
   input  logic                       tick_en,
   input  logic                       easing,
   input  logic signed [TARGET_W-1:0] target,
   input  cfg_type                    cfg,
   output logic [ANGLE_W-1:0]         angle_next,
   output logic                       reached_next
);

   logic [ANGLE_W-1:0] angle_now_ff, angle_now_in;
   logic [ANGLE_W-1:0] angle_goal_ff, angle_goal_in;
   logic               ease_mode_ff, ease_mode_in;

   logic [ANGLE_W-1:0]         target_clamped;
   logic                       moving_up;
   logic [ANGLE_W-1:0]         span;
   logic [2*ANGLE_W-1:0]       product;
   logic [ANGLE_W-1:0]         ease_step;
   logic [ANGLE_W-1:0]         step;

   // Clamp the requested angle into the servo's range.
   always_comb begin
      if (target[TARGET_W-1]) begin
         target_clamped = '0;
      end else if (target > $signed({2'b00, ANGLE_MAX})) begin
         target_clamped = ANGLE_MAX;
      end else begin
         target_clamped = target[ANGLE_W-1:0];
      end
   end

   // Step: eased share of the distance, limited to max then min, or constant.
   always_comb begin
      moving_up = angle_goal_ff > angle_now_ff;
      span      = moving_up ? (angle_goal_ff - angle_now_ff)
                            : (angle_now_ff - angle_goal_ff);
      product   = {{ANGLE_W{1'b0}}, span} * {{ANGLE_W{1'b0}}, cfg.ease_ratio_q8};
      ease_step = product[2*ANGLE_W-1:ANGLE_W];
      if (ease_step > cfg.ease_max_step) begin
         ease_step = cfg.ease_max_step;
      end
      if (ease_step < cfg.ease_min_step) begin
         ease_step = cfg.ease_min_step;
      end
      step = (ease_mode_ff == MODE_EASING) ? ease_step : cfg.constant_step;
      if (step > span) begin
         step = span;
      end
   end

   // Next state of the lane.
   always_comb begin
      angle_now_in  = angle_now_ff;
      angle_goal_in = angle_goal_ff;
      ease_mode_in  = ease_mode_ff;
      if (load_en) begin
         angle_goal_in = target_clamped;
         ease_mode_in  = easing;
      end else if (tick_en) begin
         angle_now_in = moving_up ? (angle_now_ff + step) : (angle_now_ff - step);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_now_ff  <= ANGLE_RESET;
         angle_goal_ff <= ANGLE_RESET;
         ease_mode_ff  <= MODE_CONSTANT;
      end else begin
         angle_now_ff  <= angle_now_in;
         angle_goal_ff <= angle_goal_in;
         ease_mode_ff  <= ease_mode_in;
      end
   end

   assign angle_next   = angle_now_in;
   assign reached_next = (angle_now_in == angle_goal_in);

endmodule

// ----- sv/sse_merge.sv -----
// ----------------------------------------------------------------------------
// Servo slew result stage
// Turns the lanes' new angles into duties, combines their reached flags and
// holds the result transaction until the consumer takes it.
// ----------------------------------------------------------------------------
module sse_merge
   import sse_pkg::*;
#(
   parameter int SERVO_COUNT = SERVO_COUNT_DEFAULT
)
(
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                take,
   input  logic [SERVO_COUNT-1:0][ANGLE_W-1:0] angle_next,
   input  logic [SERVO_COUNT-1:0]              reached_next,
   output logic                                slot_free,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [LANES-1:0][DUTY_W-1:0]        rsp_duty,
   output logic                                rsp_all_reached
);

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [LANES-1:0][DUTY_W-1:0] duty_ff, duty_in;
   logic                         settled_ff;

   // Duty lookup per port; ports without a servo read zero.
   for (genvar n = 0; n < LANES; n++) begin : g_duty
      if (n < SERVO_COUNT) begin : g_present
         assign duty_in[n] = DUTY_TABLE[angle_next[n]];
      end else begin : g_absent
         assign duty_in[n] = '0;
      end
   end

   // Output register may be reloaded whenever it is empty or being emptied.
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload is captured with each accepted transaction.
   always_ff @(posedge clock) begin
      if (take) begin
         duty_ff    <= duty_in;
         settled_ff <= &reached_next;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_duty        = duty_ff;
   assign rsp_all_reached = settled_ff;

endmodule

// ----- sv/servo_slew_motion_engine.sv -----
// ----------------------------------------------------------------------------
// Servo slew motion engine
// Moves a set of servos toward their goal angles one step per tick and
// reports each servo's 14-bit PWM duty after every transaction.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake            Carries
//   req_      in         req_valid/req_ready  tick or load, mask, mode, targets
//   rsp_      out        rsp_valid/rsp_ready  four duties, all-reached flag
//   csr_      in         csr_valid/csr_ready  register index and data
//
// Every lane steps in the cycle a request is accepted; the result appears
// in the output register in the next cycle. A request is taken whenever
// that register is empty or being read, so one transaction is taken per
// clock and only a stalled consumer holds the input back. Configuration
// writes are always taken. Synchronous reset puts every servo at 90
// degrees, goal 90, constant-speed mode, and restores register defaults.
// ----------------------------------------------------------------------------
module servo_slew_motion_engine
   import sse_pkg::*;
#(
   parameter int SERVO_COUNT = SERVO_COUNT_DEFAULT
)
(
   input  logic                       clock,
   input  logic                       reset,

   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_type,
   input  logic [MASK_W-1:0]          req_servo_mask,
   input  logic                       req_easing,
   input  logic signed [TARGET_W-1:0] req_target_a,
   input  logic signed [TARGET_W-1:0] req_target_b,
   input  logic signed [TARGET_W-1:0] req_target_c,
   input  logic signed [TARGET_W-1:0] req_target_d,

   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [DUTY_W-1:0]          rsp_duty_a,
   output logic [DUTY_W-1:0]          rsp_duty_b,
   output logic [DUTY_W-1:0]          rsp_duty_c,
   output logic [DUTY_W-1:0]          rsp_duty_d,
   output logic                       rsp_all_reached,

   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_W-1:0]     csr_index,
   input  logic [CFG_W-1:0]           csr_data
);

   cfg_type cfg_ff, cfg_in;

   logic                                slot_free;
   logic                                take;
   logic                                tick_en;
   logic                                load_en;
   logic [LANES-1:0][TARGET_W-1:0]      targets;
   logic [LANES-1:0][DUTY_W-1:0]        duties;
   logic [SERVO_COUNT-1:0][ANGLE_W-1:0] angle_next;
   logic [SERVO_COUNT-1:0]              reached_next;

   // Configuration registers.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_CONSTANT_STEP: cfg_in.constant_step = csr_data;
            CSR_EASE_RATIO:    cfg_in.ease_ratio_q8 = csr_data;
            CSR_EASE_MIN:      cfg_in.ease_min_step = csr_data;
            CSR_EASE_MAX:      cfg_in.ease_max_step = csr_data;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.constant_step <= CONSTANT_STEP_RESET;
         cfg_ff.ease_ratio_q8 <= EASE_RATIO_RESET;
         cfg_ff.ease_min_step <= EASE_MIN_RESET;
         cfg_ff.ease_max_step <= EASE_MAX_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Request transaction decode.
   assign req_ready = slot_free;
   assign take      = req_valid && slot_free;
   assign tick_en   = take && (req_type == REQ_TICK);
   assign load_en   = take && (req_type == REQ_LOAD);

   assign targets = {req_target_d, req_target_c, req_target_b, req_target_a};

   // One lane per servo; servos without a target port never take a load.
   for (genvar n = 0; n < SERVO_COUNT; n++) begin : g_lane
      if (n < LANES) begin : g_ported
         sse_lane u_lane (
            .clock        (clock),
            .reset        (reset),
            .load_en      (load_en && req_servo_mask[n]),
            .tick_en      (tick_en),
            .easing       (req_easing),
            .target       (targets[n]),
            .cfg          (cfg_ff),
            .angle_next   (angle_next[n]),
            .reached_next (reached_next[n])
         );
      end else begin : g_fixed
         sse_lane u_lane (
            .clock        (clock),
            .reset        (reset),
            .load_en      (1'b0),
            .tick_en      (tick_en),
            .easing       (MODE_CONSTANT),
            .target       ('0),
            .cfg          (cfg_ff),
            .angle_next   (angle_next[n]),
            .reached_next (reached_next[n])
         );
      end
   end

   // Result stage.
   sse_merge #(
      .SERVO_COUNT (SERVO_COUNT)
   ) u_merge (
      .clock           (clock),
      .reset           (reset),
      .take            (take),
      .angle_next      (angle_next),
      .reached_next    (reached_next),
      .slot_free       (slot_free),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_duty        (duties),
      .rsp_all_reached (rsp_all_reached)
   );

   assign rsp_duty_a = duties[0];
   assign rsp_duty_b = duties[1];
   assign rsp_duty_c = duties[2];
   assign rsp_duty_d = duties[3];

endmodule

// ----- tb/sv/servo_slew_motion_engine_tb.sv -----
// ----------------------------------------------------------------------------
// Servo slew motion engine testbench
// Drives tick and load transactions with random gaps against a
// random-stalling consumer. Every result is checked against an in-bench
// model of the four servo lanes, under several register settings that
// include the corner values.
// ----------------------------------------------------------------------------
module servo_slew_motion_engine_tb;
   import sse_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int RESET_CYCLES = 12;
   localparam int DRAIN_CYCLES = 3;
   localparam int MAX_WAIT     = 4;
   localparam int RANDOM_PHASES = 10;
   localparam int PHASE_ITEMS  = 80;

   // Pulse width arithmetic for the duty: (4500 + 100 * angle) * 16383 / 180000.
   localparam int PULSE_BASE  = 4500;
   localparam int PULSE_SCALE = 100;
   localparam int PWM_FULL    = 16383;
   localparam int PULSE_DEN   = 180000;

   typedef logic [LANES-1:0][TARGET_W-1:0] target_set_type;

   typedef struct packed {
      logic [DUTY_W-1:0] duty_a;
      logic [DUTY_W-1:0] duty_b;
      logic [DUTY_W-1:0] duty_c;
      logic [DUTY_W-1:0] duty_d;
      logic              settled;
   } servo_report_type;

   logic                       clock           = 1'b0;
   logic                       reset           = 1'b1;
   logic                       req_valid       = 1'b0;
   logic                       req_ready;
   logic                       req_type        = REQ_TICK;
   logic [MASK_W-1:0]          req_servo_mask  = '0;
   logic                       req_easing      = MODE_CONSTANT;
   logic signed [TARGET_W-1:0] req_target_a    = '0;
   logic signed [TARGET_W-1:0] req_target_b    = '0;
   logic signed [TARGET_W-1:0] req_target_c    = '0;
   logic signed [TARGET_W-1:0] req_target_d    = '0;
   logic                       rsp_valid;
   logic                       rsp_ready       = 1'b0;
   logic [DUTY_W-1:0]          rsp_duty_a;
   logic [DUTY_W-1:0]          rsp_duty_b;
   logic [DUTY_W-1:0]          rsp_duty_c;
   logic [DUTY_W-1:0]          rsp_duty_d;
   logic                       rsp_all_reached;
   logic                       csr_valid       = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_W-1:0]     csr_index       = '0;
   logic [CFG_W-1:0]           csr_data        = '0;

   // Model state of the servo lanes and the registers.
   logic [ANGLE_W-1:0] now_angle   [LANES];
   logic [ANGLE_W-1:0] goal_angle  [LANES];
   logic               lane_easing [LANES];
   cfg_type            model_cfg;

   servo_report_type pending_reports[$];
   int               failures    = 0;
   int               items_sent  = 0;
   int               cycle_count = 0;
   int               rsp_hold    = 0;
   bit               quiet_phase = 1'b0;

   servo_slew_motion_engine u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_type        (req_type),
      .req_servo_mask  (req_servo_mask),
      .req_easing      (req_easing),
      .req_target_a    (req_target_a),
      .req_target_b    (req_target_b),
      .req_target_c    (req_target_c),
      .req_target_d    (req_target_d),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_duty_a      (rsp_duty_a),
      .rsp_duty_b      (rsp_duty_b),
      .rsp_duty_c      (rsp_duty_c),
      .rsp_duty_d      (rsp_duty_d),
      .rsp_all_reached (rsp_all_reached),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always #1 clock = ~clock;

   // Idle cycles before the next transaction on either side.
   function automatic int draw_wait();
      if (quiet_phase) return 0;
      return $urandom_range(0, MAX_WAIT);
   endfunction

   // Requested angle as a signed 10-bit value, clamped to 0..180 degrees.
   function automatic logic [ANGLE_W-1:0] clamp_angle(input logic [TARGET_W-1:0] raw);
      int value;
      value = $signed(raw);
      if (value < 0) return '0;
      if (value > int'(ANGLE_MAX)) return ANGLE_MAX;
      return ANGLE_W'(value);
   endfunction

   function automatic logic [DUTY_W-1:0] duty_of(input logic [ANGLE_W-1:0] angle);
      int unsigned wide;
      wide = ((PULSE_BASE + PULSE_SCALE * int'(angle)) * PWM_FULL) / PULSE_DEN;
      return DUTY_W'(wide);
   endfunction

   // One step of lane n toward its goal, never past it.
   function automatic logic [ANGLE_W-1:0] next_angle(input int n);
      int cur;
      int goal;
      int span;
      int stride;
      cur  = int'(now_angle[n]);
      goal = int'(goal_angle[n]);
      if (cur == goal) return now_angle[n];
      span = (goal > cur) ? goal - cur : cur - goal;
      if (lane_easing[n] == MODE_EASING) begin
         stride = (span * int'(model_cfg.ease_ratio_q8)) >>> 8;
         if (stride > int'(model_cfg.ease_max_step)) stride = int'(model_cfg.ease_max_step);
         if (stride < int'(model_cfg.ease_min_step)) stride = int'(model_cfg.ease_min_step);
      end else begin
         stride = int'(model_cfg.constant_step);
      end
      if (stride > span) stride = span;
      return ANGLE_W'((goal > cur) ? cur + stride : cur - stride);
   endfunction

   // Applies one transaction to the lane model and returns the duties after it.
   function automatic servo_report_type predict_servos(input logic kind,
                                                       input logic [MASK_W-1:0] mask,
                                                       input logic mode,
                                                       input target_set_type targets);
      servo_report_type report;
      if (kind == REQ_LOAD) begin
         for (int n = 0; n < LANES; n++) begin
            if (mask[n]) begin
               goal_angle[n]  = clamp_angle(targets[n]);
               lane_easing[n] = mode;
            end
         end
      end else begin
         for (int n = 0; n < LANES; n++) now_angle[n] = next_angle(n);
      end
      report.duty_a  = duty_of(now_angle[0]);
      report.duty_b  = duty_of(now_angle[1]);
      report.duty_c  = duty_of(now_angle[2]);
      report.duty_d  = duty_of(now_angle[3]);
      report.settled = 1'b1;
      for (int n = 0; n < LANES; n++) begin
         if (now_angle[n] != goal_angle[n]) report.settled = 1'b0;
      end
      return report;
   endfunction

   function automatic target_set_type lanes(input int a, input int b, input int c, input int d);
      return {TARGET_W'(d), TARGET_W'(c), TARGET_W'(b), TARGET_W'(a)};
   endfunction

   // Mostly reachable angles; a quarter anywhere in the 10-bit range.
   function automatic target_set_type pick_targets();
      target_set_type targets;
      for (int n = 0; n < LANES; n++) begin
         if ($urandom_range(0, 3) == 0) targets[n] = TARGET_W'($urandom_range(0, 1023));
         else targets[n] = TARGET_W'($urandom_range(0, int'(ANGLE_MAX)));
      end
      return targets;
   endfunction

   // Register value, weighted toward the corners.
   function automatic logic [CFG_W-1:0] pick_register();
      case ($urandom_range(0, 9))
         0: return 8'd0;
         1: return 8'd1;
         2: return ANGLE_MAX;
         3: return 8'd255;
         default: return CFG_W'($urandom_range(0, 255));
      endcase
   endfunction

   // Sends one request transaction and records the result it must produce.
   // Valid is left high so that a following transaction can go back to back.
   task automatic send_item(input logic kind, input logic [MASK_W-1:0] mask,
                            input logic mode, input target_set_type targets);
      int gap;
      gap = draw_wait();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_type       <= kind;
      req_servo_mask <= mask;
      req_easing     <= mode;
      req_target_a   <= targets[0];
      req_target_b   <= targets[1];
      req_target_c   <= targets[2];
      req_target_d   <= targets[3];
      do @(posedge clock); while (!req_ready);
      pending_reports.push_back(predict_servos(kind, mask, mode, targets));
      items_sent++;
   endtask

   // A tick carries random mask, mode and targets, which it must ignore.
   task automatic send_tick();
      send_item(REQ_TICK, MASK_W'($urandom_range(0, 15)), 1'(($urandom_range(0, 1))),
                pick_targets());
   endtask

   task automatic send_ticks(input int count);
      repeat (count) send_tick();
   endtask

   // Stops sending and waits until every expected result has arrived.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input csr_index_type index, input logic [CFG_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (index)
         CSR_CONSTANT_STEP: model_cfg.constant_step = value;
         CSR_EASE_RATIO:    model_cfg.ease_ratio_q8 = value;
         CSR_EASE_MIN:      model_cfg.ease_min_step = value;
         CSR_EASE_MAX:      model_cfg.ease_max_step = value;
         default: ;
      endcase
   endtask

   // Writes all four registers; only called with the block idle.
   task automatic program_registers(input logic [CFG_W-1:0] stride, input logic [CFG_W-1:0] ratio,
                                    input logic [CFG_W-1:0] lowest, input logic [CFG_W-1:0] highest);
      drain_results();
      write_register(CSR_CONSTANT_STEP, stride);
      write_register(CSR_EASE_RATIO, ratio);
      write_register(CSR_EASE_MIN, lowest);
      write_register(CSR_EASE_MAX, highest);
      csr_valid <= 1'b0;
   endtask

   // Straight after reset every servo rests at 90 degrees; a load with an
   // empty mask changes nothing.
   task automatic test_reset_state();
      send_tick();
      send_item(REQ_LOAD, 4'b0000, MODE_EASING, lanes(0, 180, -256, 511));
   endtask

   // Targets outside 0..180 are clamped; a partial mask leaves other lanes alone.
   task automatic test_target_clamp();
      send_item(REQ_LOAD, 4'b1111, MODE_CONSTANT, lanes(-256, 511, -1, 181));
      send_tick();
      send_item(REQ_LOAD, 4'b1010, MODE_CONSTANT, lanes(7, 180, 9, 0));
      send_tick();
   endtask

   // Constant speed with the default step, finishing on a step cut short at the goal.
   task automatic test_constant_speed();
      send_item(REQ_LOAD, 4'b1111, MODE_CONSTANT, lanes(93, 87, 100, 90));
      send_ticks(3);
   endtask

   // Proportional steps, including the minimum step near the goal.
   task automatic test_easing_steps();
      send_item(REQ_LOAD, 4'b1111, MODE_EASING, lanes(0, 180, 92, 89));
      send_ticks(3);
   endtask

   // Zero steps, minimum above maximum and the largest register values.
   task automatic test_register_corners();
      program_registers(8'd0, 8'd0, 8'd0, 8'd10);
      send_item(REQ_LOAD, 4'b0011, MODE_EASING, lanes(0, 180, 0, 180));
      send_item(REQ_LOAD, 4'b1100, MODE_CONSTANT, lanes(0, 180, 0, 180));
      send_ticks(2);
      program_registers(8'd255, 8'd255, 8'd50, 8'd20);
      send_ticks(2);
      program_registers(8'd180, 8'd255, 8'd180, 8'd180);
      send_item(REQ_LOAD, 4'b1111, MODE_EASING, lanes(180, 0, 180, 0));
      send_tick();
   endtask

   // Random phases: each writes fresh registers, then loads new goals and ticks
   // the servos toward them, with noise loads and retargets in flight. The last
   // phase restores the reset values.
   task automatic test_random_motion();
      int phase_start;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         if (phase == RANDOM_PHASES - 1) begin
            program_registers(CONSTANT_STEP_RESET, EASE_RATIO_RESET, EASE_MIN_RESET,
                              EASE_MAX_RESET);
         end else begin
            program_registers(pick_register(), pick_register(), pick_register(),
                              pick_register());
         end
         quiet_phase = (phase % 4 == 2);
         phase_start = items_sent;
         while (items_sent - phase_start < PHASE_ITEMS) begin
            send_item(REQ_LOAD, MASK_W'($urandom_range(0, 15)), 1'(($urandom_range(0, 1))),
                      pick_targets());
            if ($urandom_range(0, 5) == 0) begin
               send_ticks($urandom_range(0, 3));
               send_item(REQ_LOAD, MASK_W'($urandom_range(0, 15)), 1'(($urandom_range(0, 1))),
                         pick_targets());
            end
            send_ticks($urandom_range(1, 30));
         end
      end
      quiet_phase = 1'b0;
   endtask

   // Consumer side: random stalls and a field-by-field check of each result.
   task automatic compare_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin : check_results
      servo_report_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_hold = draw_wait();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_reports.size() == 0) begin
               $display("%0t: result with nothing expected, got duties %0d %0d %0d %0d",
                        $time, rsp_duty_a, rsp_duty_b, rsp_duty_c, rsp_duty_d);
               failures++;
            end else begin
               want = pending_reports.pop_front();
               compare_field("duty_a", want.duty_a, rsp_duty_a);
               compare_field("duty_b", want.duty_b, rsp_duty_b);
               compare_field("duty_c", want.duty_c, rsp_duty_c);
               compare_field("duty_d", want.duty_d, rsp_duty_d);
               compare_field("settled flag", want.settled, rsp_all_reached);
            end
            rsp_hold = draw_wait();
         end else if (rsp_hold != 0) begin
            rsp_hold--;
         end
         rsp_ready <= (rsp_hold == 0);
      end
   end

   // Watchdog on the whole run.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("%0t: run timed out", $time);
      $display("** servo_slew_motion_engine: FAILED **");
      $finish;
   end

   initial begin
      for (int n = 0; n < LANES; n++) begin
         now_angle[n]   = ANGLE_RESET;
         goal_angle[n]  = ANGLE_RESET;
         lane_easing[n] = MODE_CONSTANT;
      end
      model_cfg = {CONSTANT_STEP_RESET, EASE_RATIO_RESET, EASE_MIN_RESET, EASE_MAX_RESET};
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_target_clamp();
      test_constant_speed();
      test_easing_steps();
      test_register_corners();
      test_random_motion();
      drain_results();

      if (pending_reports.size() != 0) begin
         $display("%0t: %0d expected results never arrived", $time, pending_reports.size());
         failures++;
      end
      if (failures == 0) begin
         $display("** servo_slew_motion_engine: PASSED **");
      end else begin
         $display("** servo_slew_motion_engine: FAILED **");
      end
      $finish;
   end

endmodule
